FILE: sv/bpsd_pkg.sv
// Shared types, codes and conversion functions of the BMP pixel stream decoder.
package bpsd_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] FMT_RGB555 = 2'd0;
    localparam logic [1:0] FMT_BGR24  = 2'd1;
    localparam logic [1:0] FMT_BGRA32 = 2'd2;
    localparam logic [1:0] FMT_NONE   = 2'd3;

    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_IMAGE_ROWS     = 3'd1;
    localparam logic [2:0] REG_BOTTOM_UP      = 3'd2;
    localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X       = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y       = 3'd5;
    localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd6;
    localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd7;

    typedef struct packed {
        logic        last;
        logic [1:0]  fmt;
        logic [31:0] bytes;
    } pix_info_t;

    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [12:0] scaled;
        logic [27:0] prod;
        begin
            scaled = {c, 8'd0} - 13'(c);
            prod   = 28'(scaled) * 28'd16913;
            expand5 = prod[26:19];
        end
    endfunction

    function automatic logic [12:0] dim_eff(input logic [12:0] v, input int max_dim);
        begin
            if (v == 13'd0)
                dim_eff = 13'd1;
            else if (int'(v) > max_dim)
                dim_eff = 13'(max_dim);
            else
                dim_eff = v;
        end
    endfunction

    function automatic logic [12:0] surf_eff(input logic [12:0] v, input int max_dim);
        begin
            if (int'(v) > max_dim)
                surf_eff = 13'(max_dim);
            else
                surf_eff = v;
        end
    endfunction

endpackage

FILE: sv/bpsd_front.sv
// Byte intake: padding skip, pixel byte gathering, column and row counting.
module bpsd_front #(
    parameter int MAX_DIM = bpsd_pkg::MAX_DIM_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       first_byte,
    input  logic [1:0]                 pixel_format,
    input  logic [12:0]                w_eff,
    input  logic [12:0]                h_eff,
    input  logic                       queue_full,
    output logic                       push,
    output bpsd_pkg::pix_info_t        push_info,
    output logic [$clog2(MAX_DIM)-1:0] push_col,
    output logic [$clog2(MAX_DIM)-1:0] push_row
);
    import bpsd_pkg::*;

    localparam int CW   = $clog2(MAX_DIM);
    localparam int CMPW = ((CW > 13) ? CW : 13) + 1;

    logic [23:0]   gather_reg, gather_next, gather_cur;
    logic [1:0]    bip_reg, bip_next, bip_cur;
    logic [CW-1:0] col_reg, col_next, col_cur;
    logic [CW-1:0] row_reg, row_next, row_cur;
    logic [1:0]    pad_reg, pad_next, pad_cur;
    logic          inpad_reg, inpad_next, inpad_cur;
    logic          accept;
    logic [2:0]    bpp;
    logic [3:0]    row_bytes_low;
    logic [1:0]    pad_len;
    logic          row_end;
    logic          img_end;

    assign in_stall = queue_full;
    assign accept   = in_valid & ~queue_full;

    assign gather_cur = first_byte ? 24'd0 : gather_reg;
    assign bip_cur    = first_byte ? 2'd0 : bip_reg;
    assign col_cur    = first_byte ? '0 : col_reg;
    assign row_cur    = first_byte ? '0 : row_reg;
    assign pad_cur    = first_byte ? 2'd0 : pad_reg;
    assign inpad_cur  = first_byte ? 1'b0 : inpad_reg;

    assign bpp           = {1'b0, pixel_format} + 3'd2;
    assign row_bytes_low = 4'(w_eff[1:0]) * 4'(bpp);
    assign pad_len       = 2'd0 - row_bytes_low[1:0];
    assign row_end       = (CMPW'(col_cur) + CMPW'(1)) >= CMPW'(w_eff);
    assign img_end       = (CMPW'(row_cur) + CMPW'(1)) >= CMPW'(h_eff);

    always_comb
    begin
        gather_next = gather_reg;
        bip_next    = bip_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        inpad_next  = inpad_reg;
        push        = 1'b0;
        push_info   = '{last: 1'b0, fmt: pixel_format, bytes: {data_byte, gather_cur}};
        push_col    = col_cur;
        push_row    = row_cur;
        if (accept)
        begin
            gather_next = gather_cur;
            bip_next    = bip_cur;
            col_next    = col_cur;
            row_next    = row_cur;
            pad_next    = pad_cur;
            inpad_next  = inpad_cur;
            if (pixel_format != FMT_NONE)
            begin
                if (inpad_cur)
                begin
                    if (pad_cur <= 2'd1)
                    begin
                        pad_next   = 2'd0;
                        inpad_next = 1'b0;
                    end
                    else
                    begin
                        pad_next = pad_cur - 2'd1;
                    end
                end
                else if (({1'b0, bip_cur} + 3'd1) < bpp)
                begin
                    case (bip_cur)
                        2'd0:    gather_next = gather_cur | {16'd0, data_byte};
                        2'd1:    gather_next = gather_cur | {8'd0, data_byte, 8'd0};
                        2'd2:    gather_next = gather_cur | {data_byte, 16'd0};
                        default: gather_next = gather_cur;
                    endcase
                    bip_next = bip_cur + 2'd1;
                end
                else
                begin
                    push        = 1'b1;
                    gather_next = 24'd0;
                    bip_next    = 2'd0;
                    if (row_end)
                    begin
                        col_next = '0;
                        if (img_end)
                        begin
                            row_next       = '0;
                            push_info.last = 1'b1;
                        end
                        else
                        begin
                            row_next = row_cur + CW'(1);
                        end
                        if (pad_len != 2'd0)
                        begin
                            pad_next   = pad_len;
                            inpad_next = 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_cur + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg <= 24'd0;
            bip_reg    <= 2'd0;
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= 2'd0;
            inpad_reg  <= 1'b0;
        end
        else
        begin
            gather_reg <= gather_next;
            bip_reg    <= bip_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
            inpad_reg  <= inpad_next;
        end
    end

endmodule

FILE: sv/bpsd_queue.sv
// Short register queue between pixel intake and pixel output.
module bpsd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bpsd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign full     = (count_reg == NW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: sv/bpsd_back.sv
// Pixel output: color expansion, surface mapping, clipping and output register.
module bpsd_back #(
    parameter int MAX_DIM = bpsd_pkg::MAX_DIM_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       queue_empty,
    output logic                       pop,
    input  bpsd_pkg::pix_info_t        pop_info,
    input  logic [$clog2(MAX_DIM)-1:0] pop_col,
    input  logic [$clog2(MAX_DIM)-1:0] pop_row,
    input  logic                       bottom_up,
    input  logic [12:0]                h_eff,
    input  logic signed [13:0]         origin_x,
    input  logic signed [13:0]         origin_y,
    input  logic [12:0]                sw_eff,
    input  logic [12:0]                sh_eff,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [11:0]                pixel_x,
    output logic [11:0]                pixel_y,
    output logic [7:0]                 alpha,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue,
    output logic                       blend_write,
    output logic                       visible,
    output logic                       last_pixel
);
    import bpsd_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int SW = (((CW + 1) > 14) ? (CW + 1) : 14) + 2;
    localparam logic signed [SW-1:0] ONE_S = 1;

    logic                 out_valid_reg, out_valid_next;
    logic [11:0]          pixel_x_reg, pixel_y_reg;
    logic [7:0]           alpha_reg, red_reg, green_reg, blue_reg;
    logic                 blend_reg, visible_reg, last_reg;
    logic [7:0]           a_c, r_c, g_c, b_c;
    logic                 blend_c;
    logic [15:0]          word555;
    logic signed [SW-1:0] col_s, row_s, h_s, img_row, sx, sy;
    logic                 vis_c;

    assign pop            = ~queue_empty & (~out_valid_reg | ~out_stall);
    assign out_valid_next = pop | (out_valid_reg & out_stall);

    assign word555 = {pop_info.bytes[31:24], pop_info.bytes[7:0]};

    always_comb
    begin
        case (pop_info.fmt)
            FMT_RGB555:
            begin
                b_c     = expand5(word555[4:0]);
                g_c     = expand5(word555[9:5]);
                r_c     = expand5(word555[14:10]);
                a_c     = 8'hFF;
                blend_c = 1'b0;
            end
            FMT_BGR24:
            begin
                b_c     = pop_info.bytes[7:0];
                g_c     = pop_info.bytes[15:8];
                r_c     = pop_info.bytes[31:24];
                a_c     = 8'hFF;
                blend_c = 1'b0;
            end
            default:
            begin
                b_c     = pop_info.bytes[7:0];
                g_c     = pop_info.bytes[15:8];
                r_c     = pop_info.bytes[23:16];
                a_c     = pop_info.bytes[31:24];
                blend_c = 1'b1;
            end
        endcase
    end

    assign col_s   = signed'(SW'(pop_col));
    assign row_s   = signed'(SW'(pop_row));
    assign h_s     = signed'(SW'(h_eff));
    assign img_row = bottom_up ? (h_s - ONE_S - row_s) : row_s;
    assign sx      = SW'(origin_x) + col_s;
    assign sy      = SW'(origin_y) + img_row;
    assign vis_c   = (sx >= 0) && (sy >= 0)
                     && (sx < signed'(SW'(sw_eff))) && (sy < signed'(SW'(sh_eff)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pixel_x_reg <= vis_c ? sx[11:0] : 12'd0;
            pixel_y_reg <= vis_c ? sy[11:0] : 12'd0;
            alpha_reg   <= a_c;
            red_reg     <= r_c;
            green_reg   <= g_c;
            blue_reg    <= b_c;
            blend_reg   <= blend_c;
            visible_reg <= vis_c;
            last_reg    <= pop_info.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign alpha       = alpha_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign blend_write = blend_reg;
    assign visible     = visible_reg;
    assign last_pixel  = last_reg;

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !visible_reg) |-> (pixel_x_reg == 12'd0 && pixel_y_reg == 12'd0))
        else $error("hidden pixel carries coordinates");

endmodule

FILE: sv/bmp_pixel_stream_decoder.sv
// Top level of the BMP pixel stream decoder: registers, intake, queue, output.
//
//  channel | signals                                   | dir | handshake
//  in      | data_byte, first_byte                     | in  | in_valid / in_stall
//  out     | pixel_x/y, alpha/red/green/blue, flags    | out | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                       | in  | cfg_valid / cfg_ready
//
//  One byte request per cycle is taken while in_stall is low; a finished pixel is written
//  into a queue entry and then into the output register. The intake decides each byte in
//  the cycle it is taken.
//  Reset loads the register defaults and clears all counters and the queue.
//  in_stall rises only while the two-entry queue is full; cfg_ready is always high.
module bmp_pixel_stream_decoder #(
    parameter int MAX_DIM = bpsd_pkg::MAX_DIM_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y,
    output logic [7:0]  alpha,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        blend_write,
    output logic        visible,
    output logic        last_pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);
    import bpsd_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int QW = $bits(pix_info_t) + 2 * CW;

    logic [12:0]        image_width_reg, image_rows_reg;
    logic               bottom_up_reg;
    logic [1:0]         pixel_format_reg;
    logic signed [13:0] origin_x_reg, origin_y_reg;
    logic [12:0]        surface_width_reg, surface_height_reg;
    logic [12:0]        w_eff, h_eff, sw_eff, sh_eff;

    logic               push, pop, queue_full, queue_empty;
    pix_info_t          push_info, pop_info;
    logic [CW-1:0]      push_col, push_row, pop_col, pop_row;
    logic [QW-1:0]      push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= 13'd1;
            image_rows_reg     <= 13'd1;
            bottom_up_reg      <= 1'b1;
            pixel_format_reg   <= FMT_BGR24;
            origin_x_reg       <= 14'sd0;
            origin_y_reg       <= 14'sd0;
            surface_width_reg  <= 13'd1;
            surface_height_reg <= 13'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[12:0];
                REG_IMAGE_ROWS:     image_rows_reg     <= cfg_data[12:0];
                REG_BOTTOM_UP:      bottom_up_reg      <= cfg_data[0];
                REG_PIXEL_FORMAT:   pixel_format_reg   <= cfg_data[1:0];
                REG_ORIGIN_X:       origin_x_reg       <= signed'(cfg_data);
                REG_ORIGIN_Y:       origin_y_reg       <= signed'(cfg_data);
                REG_SURFACE_WIDTH:  surface_width_reg  <= cfg_data[12:0];
                REG_SURFACE_HEIGHT: surface_height_reg <= cfg_data[12:0];
                default:            image_width_reg    <= image_width_reg;
            endcase
        end
    end

    assign w_eff  = dim_eff(image_width_reg, MAX_DIM);
    assign h_eff  = dim_eff(image_rows_reg, MAX_DIM);
    assign sw_eff = surf_eff(surface_width_reg, MAX_DIM);
    assign sh_eff = surf_eff(surface_height_reg, MAX_DIM);

    bpsd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .pixel_format (pixel_format_reg),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .queue_full   (queue_full),
        .push         (push),
        .push_info    (push_info),
        .push_col     (push_col),
        .push_row     (push_row)
    );

    assign push_data = {push_info, push_col, push_row};
    assign {pop_info, pop_col, pop_row} = pop_data;

    bpsd_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    bpsd_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop         (pop),
        .pop_info    (pop_info),
        .pop_col     (pop_col),
        .pop_row     (pop_row),
        .bottom_up   (bottom_up_reg),
        .h_eff       (h_eff),
        .origin_x    (origin_x_reg),
        .origin_y    (origin_y_reg),
        .sw_eff      (sw_eff),
        .sh_eff      (sh_eff),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .alpha       (alpha),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .blend_write (blend_write),
        .visible     (visible),
        .last_pixel  (last_pixel)
    );

endmodule

FILE: sim/bmp_pixel_stream_decoder_tb.sv
// Self-checking testbench of the BMP pixel stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

module bmp_pixel_stream_decoder_tb;
    import bpsd_pkg::*;

    localparam int SIZE_LIMIT = MAX_DIM_DEFAULT;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        blend;
        logic        vis;
        logic        last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        first_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        blend_write;
    logic        visible;
    logic        last_pixel;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [13:0] cfg_data = 14'd0;

    logic [12:0] width_reg = 13'd1;
    logic [12:0] rows_reg = 13'd1;
    logic        bottom_up_reg = 1'b1;
    logic [1:0]  format_reg = FMT_BGR24;
    int          origin_x_reg = 0;
    int          origin_y_reg = 0;
    logic [12:0] surf_w_reg = 13'd1;
    logic [12:0] surf_h_reg = 13'd1;

    logic [23:0] gather_bytes = 24'd0;
    int          byte_idx = 0;
    int          col_idx = 0;
    int          row_idx = 0;
    int          pad_left = 0;
    bit          skipping_pad = 1'b0;

    pixel_t      expected_pixels[$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          pixels_checked = 0;
    int          reg_writes = 0;

    bmp_pixel_stream_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .alpha       (alpha),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .blend_write (blend_write),
        .visible     (visible),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int dim_used(input logic [12:0] v, input bit zero_as_one);
        if (v == 13'd0)
            return zero_as_one ? 1 : 0;
        return (int'(v) > SIZE_LIMIT) ? SIZE_LIMIT : int'(v);
    endfunction

    function automatic logic [7:0] stretch5(input logic [4:0] c);
        int v;
        v = (int'(c) * 255) / 31;
        return v[7:0];
    endfunction

    function automatic bit decode_byte(input logic [7:0] din, input logic first,
                                       output pixel_t px);
        int w;
        int h;
        int bpp;
        int pad;
        int img_row;
        int sx;
        int sy;
        logic [15:0] word;
        bit vis;
        px = '0;
        w = dim_used(width_reg, 1'b1);
        h = dim_used(rows_reg, 1'b1);
        if (first) begin
            gather_bytes = 24'd0;
            byte_idx = 0;
            col_idx = 0;
            row_idx = 0;
            pad_left = 0;
            skipping_pad = 1'b0;
        end
        if (format_reg == FMT_NONE)
            return 1'b0;
        bpp = int'(format_reg) + 2;
        if (skipping_pad) begin
            if (pad_left <= 1) begin
                pad_left = 0;
                skipping_pad = 1'b0;
            end else begin
                pad_left--;
            end
            return 1'b0;
        end
        if (byte_idx + 1 < bpp) begin
            gather_bytes = gather_bytes | ({16'd0, din} << (8 * byte_idx));
            byte_idx++;
            return 1'b0;
        end
        case (format_reg)
            FMT_RGB555:
            begin
                word = {din, gather_bytes[7:0]};
                px.blue = stretch5(word[4:0]);
                px.green = stretch5(word[9:5]);
                px.red = stretch5(word[14:10]);
                px.alpha = 8'hFF;
            end
            FMT_BGR24:
            begin
                px.blue = gather_bytes[7:0];
                px.green = gather_bytes[15:8];
                px.red = din;
                px.alpha = 8'hFF;
            end
            default:
            begin
                px.blue = gather_bytes[7:0];
                px.green = gather_bytes[15:8];
                px.red = gather_bytes[23:16];
                px.alpha = din;
            end
        endcase
        px.blend = (format_reg == FMT_BGRA32);
        gather_bytes = 24'd0;
        byte_idx = 0;
        img_row = bottom_up_reg ? h - 1 - row_idx : row_idx;
        sx = origin_x_reg + col_idx;
        sy = origin_y_reg + img_row;
        vis = sx >= 0 && sy >= 0 && sx < dim_used(surf_w_reg, 1'b0)
              && sy < dim_used(surf_h_reg, 1'b0);
        if (col_idx + 1 >= w) begin
            pad = (4 - ((w * bpp) % 4)) % 4;
            col_idx = 0;
            if (row_idx + 1 >= h) begin
                row_idx = 0;
                px.last = 1'b1;
            end else begin
                row_idx++;
            end
            if (pad != 0) begin
                pad_left = pad;
                skipping_pad = 1'b1;
            end
        end else begin
            col_idx++;
        end
        px.vis = vis;
        px.x = vis ? sx[11:0] : 12'd0;
        px.y = vis ? sy[11:0] : 12'd0;
        return 1'b1;
    endfunction

    task automatic set_reg(input logic [2:0] idx, input logic [13:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:    width_reg = val[12:0];
            REG_IMAGE_ROWS:     rows_reg = val[12:0];
            REG_BOTTOM_UP:      bottom_up_reg = val[0];
            REG_PIXEL_FORMAT:   format_reg = val[1:0];
            REG_ORIGIN_X:       origin_x_reg = int'($signed(val));
            REG_ORIGIN_Y:       origin_y_reg = int'($signed(val));
            REG_SURFACE_WIDTH:  surf_w_reg = val[12:0];
            REG_SURFACE_HEIGHT: surf_h_reg = val[12:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(input logic [13:0] w, input logic [13:0] rows,
                             input logic [13:0] bu, input logic [13:0] fmt,
                             input logic [13:0] ox, input logic [13:0] oy,
                             input logic [13:0] sw, input logic [13:0] sh);
        set_reg(REG_IMAGE_WIDTH, w);
        set_reg(REG_IMAGE_ROWS, rows);
        set_reg(REG_BOTTOM_UP, bu);
        set_reg(REG_PIXEL_FORMAT, fmt);
        set_reg(REG_ORIGIN_X, ox);
        set_reg(REG_ORIGIN_Y, oy);
        set_reg(REG_SURFACE_WIDTH, sw);
        set_reg(REG_SURFACE_HEIGHT, sh);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] val, input logic first);
        pixel_t px;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= val;
        first_byte <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (decode_byte(val, first, px))
            expected_pixels.push_back(px);
        bytes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk) begin : check_pixels
        pixel_t got;
        pixel_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = {pixel_x, pixel_y, alpha, red, green, blue, blend_write, visible, last_pixel};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: pixel with no request pending: x=%0d y=%0d", $time,
                             got.x, got.y);
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: pixel mismatch, expected x=%0d y=%0d argb=%h%h%h%h blend=%b vis=%b last=%b",
                                 $time, want.x, want.y, want.alpha, want.red, want.green,
                                 want.blue, want.blend, want.vis, want.last);
                        $display("%0t:                 actual x=%0d y=%0d argb=%h%h%h%h blend=%b vis=%b last=%b",
                                 $time, got.x, got.y, got.alpha, got.red, got.green,
                                 got.blue, got.blend, got.vis, got.last);
                    end
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h5A, 1'b0);
        drain();
    endtask

    task automatic test_pixel_formats();
        configure(14'd1, 14'd2, 14'd0, 14'(FMT_RGB555), 14'd0, 14'd0, 14'd4, 14'd4);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        drain();
        configure(14'd2, 14'd1, 14'd1, 14'(FMT_BGRA32), 14'd1, 14'd0, 14'd2, 14'd1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFD, 1'b0);
        send_byte(8'h00, 1'b0);
        drain();
    endtask

    task automatic test_saturated_sizes();
        configure(14'h1FFF, 14'h1FFF, 14'd1, 14'(FMT_BGR24), 14'd4095, 14'(-4095),
                  14'h1FFF, 14'h1FFF);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain();
    endtask

    task automatic test_unused_format();
        configure(14'd3, 14'd2, 14'd0, 14'(FMT_NONE), 14'd0, 14'd0, 14'd4, 14'd4);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        drain();
    endtask

    task automatic test_format_change_mid_pixel();
        configure(14'd2, 14'd2, 14'd1, 14'(FMT_BGRA32), 14'd0, 14'd0, 14'd4, 14'd4);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b0);
        drain();
        configure(14'd2, 14'd2, 14'd1, 14'(FMT_RGB555), 14'd0, 14'd0, 14'd4, 14'd4);
        send_byte(8'hB3, 1'b0);
        drain();
    endtask

    function automatic logic [13:0] pick_size();
        case ($urandom_range(0, 11))
            0: return 14'd0;
            1: return 14'd4096;
            2: return 14'h1FFF;
            3: return 14'($urandom_range(0, 8191));
            default: return 14'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [13:0] pick_origin();
        case ($urandom_range(0, 7))
            0: return 14'h2000;
            1: return 14'h1FFF;
            2: return 14'($urandom_range(0, 16383));
            3: return 14'($urandom_range(0, 4095));
            default: return 14'($urandom_range(0, 6) - 3);
        endcase
    endfunction

    task automatic test_random_images(input int sender_pct, input int receiver_pct,
                                      input int budget);
        int done;
        int total;
        int n;
        int bpp;
        logic [13:0] fmt;
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
        done = 0;
        while (done < budget) begin
            drain();
            fmt = ($urandom_range(0, 19) == 0) ? 14'(FMT_NONE) : 14'($urandom_range(0, 2));
            if ($urandom_range(0, 9) < 3)
                configure(pick_size(), pick_size(), 14'($urandom_range(0, 1)), fmt,
                          14'($urandom_range(0, 4095)), 14'($urandom_range(0, 4095)),
                          $urandom_range(0, 1) ? 14'd4096 : 14'h1FFF,
                          $urandom_range(0, 1) ? 14'd4096 : 14'h1FFF);
            else
                configure(pick_size(), pick_size(), 14'($urandom_range(0, 1)), fmt,
                          pick_origin(), pick_origin(), pick_size(), pick_size());
            if (format_reg == FMT_NONE) begin
                n = $urandom_range(1, 8);
            end else begin
                bpp = int'(format_reg) + 2;
                total = ((dim_used(width_reg, 1'b1) * bpp + 3) / 4) * 4
                        * dim_used(rows_reg, 1'b1);
                n = total;
                if (n > 160)
                    n = $urandom_range(20, 160);
                else if ($urandom_range(0, 99) < 15)
                    n = $urandom_range(1, total);
                else if ($urandom_range(0, 99) < 15)
                    n = total + $urandom_range(1, 12);
            end
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 99) == 0));
            if (format_reg != FMT_NONE)
                done += n;
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 20;
        stall_pct = 76;
        test_reset_defaults();
        test_pixel_formats();
        test_saturated_sizes();
        test_unused_format();
        test_format_change_mid_pixel();
        test_random_images(20, 76, 460);
        test_random_images(76, 20, 460);
        test_random_images(0, 0, 460);
        repeat (8) @(posedge clk);
        $display("Run covered %0d byte requests and %0d register writes over three pacing modes;",
                 bytes_sent, reg_writes);
        $display("%0d decoded pixels were checked, %0d mismatches.", pixels_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
